// ===== hdl/ppus_pkg.sv =====
// Shared types and constants for the packed pixel unpack and scale unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ppus_pkg;

  // Full-scale gray value of the output
  localparam logic [7:0] FullScale = 8'd255;

  // Restoring divider: one quotient bit per step over a 16-bit dividend
  localparam int DivSteps = 16;
  localparam int DivCntW  = $clog2(DivSteps);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_GRAY     = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } ppus_cfg_idx_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_byte;  // shift a new byte into the bit buffer
    logic extract;    // take one code, update counters, seed the divider
    logic div_step;   // one restoring divide step
    logic load_out;   // move the scaled pixel into the output register
  } ppus_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic code_avail; // bit buffer holds a complete code
    logic div_last;   // the current divide step is the final one
    logic out_free;   // output register can take a pixel this cycle
    logic last;       // the pending pixel is the final one of its byte
  } ppus_sts_t;

  // Code width: leading-one position of max_gray plus one, at least one bit
  function automatic logic [3:0] bits_per_pixel(input logic [7:0] g);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if ((g >> i) != 8'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== hdl/packed_pixel_unpack_scale_unit.sv =====
// Top level of the packed pixel unpack and scale unit.
// Joins ppus_ctrl and ppus_dpath; depends on ppus_pkg.
`timescale 1ns / 1ps

// Unpacks a stream of bytes into pixel codes of bits_per_pixel(max_gray) bits,
// MSB first, and emits each as code*255/max_gray saturated to 8 bits, with
// row_end, image_end and last (final pixel of the current byte) flags. A byte
// is taken while idle and checked for a complete code in the next cycle; each pixel
// it yields goes through extraction, the one-bit-per-cycle restoring divider
// that all pixels share and the load of the output register, and waits as long
// as the output register stays stalled. The unit returns to idle with the load
// of the byte's last pixel; a byte that completes no code returns it to idle
// from the check. The output register holds the final pixel of a byte while
// the next byte is taken. There is no clearing pass after reset.
// Configuration registers are written through the cfg port (always ready) and
// must only change while the unit is idle.

module packed_pixel_unpack_scale_unit
  import ppus_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packed_byte,
  // result pixels
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel,
  output logic        out_row_end,
  output logic        out_image_end,
  output logic        out_last
);

  ppus_cmd_t cmd;
  ppus_sts_t sts;

  assign cfg_ready = 1'b1;

  ppus_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppus_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_packed_byte (in_packed_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel      (out_pixel),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end),
    .out_last       (out_last)
  );

endmodule

// ===== hdl/ppus_ctrl.sv =====
// Sequencer of the packed pixel unpack and scale unit.
// Steps the datapath through byte load, code extraction, division and output.
// Depends on ppus_pkg.
`timescale 1ns / 1ps

module ppus_ctrl
  import ppus_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ppus_sts_t sts,
  output ppus_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_WAIT
  } state_t;

  state_t state_r, state_nxt;

  // Take a byte only between bytes
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.code_avail) begin
          cmd.extract = 1'b1;
          state_nxt   = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sts.last ? ST_IDLE : ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/ppus_dpath.sv =====
// Datapath of the packed pixel unpack and scale unit: configuration registers,
// bit buffer, row and image counters, serial divider and output register.
// Depends on ppus_pkg; driven by ppus_ctrl.
`timescale 1ns / 1ps

module ppus_dpath
  import ppus_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input byte
  input  logic [7:0]  in_packed_byte,
  // controller link
  input  ppus_cmd_t   cmd,
  output ppus_sts_t   sts,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel,
  output logic        out_row_end,
  output logic        out_image_end,
  output logic        out_last
);

  // Configuration
  logic [7:0]  max_gray_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [31:0] total;

  // Stream and position state
  logic [14:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] pix_done_r, pix_done_nxt;
  logic [15:0] col_r, col_nxt;
  logic [2:0]  n_r, n_nxt;

  // Pending pixel flags
  logic row_end_r, img_end_r, last_r;

  // Divider
  logic [7:0]         rem_r;
  logic [15:0]        dvd_r;
  logic [DivCntW-1:0] step_r;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_pixel_r;
  logic       out_row_end_r, out_image_end_r, out_last_r;

  // Extraction terms
  logic [3:0]  bpp;
  logic [3:0]  rest;
  logic [14:0] shifted;
  logic [7:0]  code_mask;
  logic [7:0]  code;
  logic [14:0] keep_mask;
  logic [16:0] col_inc;
  logic [31:0] pix_inc;
  logic        row_end_w, img_end_w, last_w;

  // Divide step terms
  logic [8:0]  trial;
  logic        ge;
  logic [7:0]  scaled;

  // Pixels per image, modulo 2^32
  assign total     = 32'(width_r) * 32'(height_r);

  assign bpp       = bits_per_pixel(max_gray_r);
  assign rest      = cnt_r - bpp;
  assign shifted   = buf_r >> rest;
  assign code_mask = 8'((9'd1 << bpp) - 9'd1);
  assign code      = shifted[7:0] & code_mask;
  assign keep_mask = 15'((16'd1 << rest) - 16'd1);
  assign col_inc   = {1'b0, col_r} + 17'd1;
  assign pix_inc   = pix_done_r + 32'd1;
  assign row_end_w = (col_inc == {1'b0, width_r});
  assign img_end_w = (pix_inc == total);
  // no more codes from this byte: image done, result limit hit or bits run out
  assign last_w    = img_end_w || (n_r == 3'd7) || (rest < bpp);

  assign trial  = {rem_r, dvd_r[15]};
  assign ge     = (trial >= {1'b0, max_gray_r});

  // Saturate above full scale; zero max_gray gives black
  always_comb begin
    if (max_gray_r == 8'd0)        scaled = 8'd0;
    else if (dvd_r[15:8] != 8'd0)  scaled = FullScale;
    else                           scaled = dvd_r[7:0];
  end

  // Status
  assign sts.code_avail = (cnt_r >= bpp);
  assign sts.div_last   = (step_r == DivCntW'(DivSteps - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.last       = last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gray_r <= 8'd255;
      width_r    <= 16'd640;
      height_r   <= 16'd480;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_GRAY:     max_gray_r <= cfg_data[7:0];
          CFG_IMAGE_WIDTH:  width_r    <= cfg_data;
          CFG_IMAGE_HEIGHT: height_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Next stream state
  always_comb begin
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    pix_done_nxt = pix_done_r;
    col_nxt      = col_r;
    n_nxt        = n_r;
    if (cmd.load_byte) begin
      buf_nxt = {buf_r[6:0], in_packed_byte};
      cnt_nxt = (cnt_r >= 4'd7) ? 4'd15 : cnt_r + 4'd8;
      n_nxt   = 3'd0;
    end else if (cmd.extract) begin
      n_nxt = n_r + 3'd1;
      if (img_end_w) begin
        // drop padding and restart for the next image
        buf_nxt      = '0;
        cnt_nxt      = '0;
        pix_done_nxt = '0;
        col_nxt      = '0;
      end else begin
        buf_nxt      = buf_r & keep_mask;
        cnt_nxt      = rest;
        pix_done_nxt = pix_inc;
        col_nxt      = row_end_w ? 16'd0 : col_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r      <= '0;
      cnt_r      <= '0;
      pix_done_r <= '0;
      col_r      <= '0;
      n_r        <= '0;
    end else begin
      buf_r      <= buf_nxt;
      cnt_r      <= cnt_nxt;
      pix_done_r <= pix_done_nxt;
      col_r      <= col_nxt;
      n_r        <= n_nxt;
    end
  end

  // Pending pixel flags and divider; payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.extract) begin
      row_end_r <= row_end_w;
      img_end_r <= img_end_w;
      last_r    <= last_w;
      // dividend code*255 as code*256 - code
      dvd_r     <= {code, 8'd0} - {8'd0, code};
      rem_r     <= 8'd0;
      step_r    <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[14:0], ge};
      rem_r  <= ge ? 8'(trial - {1'b0, max_gray_r}) : trial[7:0];
      step_r <= step_r + DivCntW'(1);
    end
  end

  // Output register: load a pixel, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pixel_r     <= scaled;
      out_row_end_r   <= row_end_r;
      out_image_end_r <= img_end_r;
      out_last_r      <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_image_end = out_image_end_r;
  assign out_last      = out_last_r;

endmodule

// ===== hdl/ppus_checker.sv =====
// Port-level checks for packed_pixel_unpack_scale_unit, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module ppus_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_pixel,
  input logic        out_row_end,
  input logic        out_image_end,
  input logic        out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel) &&
      $stable(out_row_end) && $stable(out_image_end) && $stable(out_last))
    else $error("stalled result changed");

  // End of image ends the byte's run of pixels
  a_img_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_last)
    else $error("image end without last");

  // One byte at a time: stall right after an input transfer
  a_in_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a byte is in work");

  // No pixel can appear in the cycle after a byte transfer
  a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too soon after input transfer");

endmodule

bind packed_pixel_unpack_scale_unit ppus_checker u_ppus_checker (.*);
